/* src/tlp_pkg.sv */
// Shared types and constants for the transcript list parser.
// No dependencies; imported by every other module of the block.
package tlp_pkg;

    // Separator bytes and digit bounds of the transcript list text
    localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
    localparam logic [7:0] CHAR_TAB        = 8'h09;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_COMMA      = 8'h2C;
    localparam logic [7:0] CHAR_AT         = 8'h40;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;
    localparam logic [7:0] CHAR_PLUS       = 8'h2B;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_NINE       = 8'h39;

    localparam int unsigned ACC_W = 32;

    // Result record kinds
    typedef enum logic [2:0] {
        KIND_ID    = 3'd0,
        KIND_LOCUS = 3'd1,
        KIND_REF   = 3'd2,
        KIND_EXON  = 3'd3,
        KIND_BAD   = 3'd4
    } kind_t;

    // Field currently being accumulated
    typedef enum logic [2:0] {
        FIELD_ID    = 3'd0,
        FIELD_LOCUS = 3'd1,
        FIELD_REF   = 3'd2,
        FIELD_START = 3'd3,
        FIELD_END   = 3'd4
    } field_t;

    // Byte classes after decode
    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_NEWLINE,
        CLS_TAB,
        CLS_UNDERSCORE,
        CLS_COMMA,
        CLS_AT,
        CLS_STRAND,
        CLS_BAD
    } byte_class_t;

    typedef struct packed {
        byte_class_t cls;
        logic [3:0]  digit;
        logic        minus;
    } decode_t;

    typedef struct packed {
        kind_t              kind;
        logic [ACC_W-1:0]   value;
        logic               strand_minus;
        logic [ACC_W-1:0]   exon_start;
        logic [ACC_W-1:0]   exon_end;
        logic               transcript_done;
    } result_t;

endpackage

/* src/transcript_list_parser.sv */
// Top level of the transcript list parser: input register, decode and field
// logic, result register. Depends on tlp_pkg, tlp_decode and tlp_fields.
//
//  channel | ports                          | carries
//  --------+--------------------------------+------------------------------
//  input   | s_valid s_ready s_byte_in      | one text byte per request
//  result  | m_valid m_ready m_kind ...     | one record per emitting byte
//
// One byte per cycle sustained unless a held result stalls an emitting byte;
// an accepted byte loads the input register, and an emitting byte then loads
// the result register when it advances.
// Digits and underscores update state and produce no result.
// A held result stalls only a byte that must emit; others pass through.
// aresetn is synchronous and clears all fields to the id field with zeros.
module transcript_list_parser
    import tlp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_byte_in,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_kind,
    output logic [ACC_W-1:0] m_value,
    output logic             m_strand_minus,
    output logic [ACC_W-1:0] m_exon_start,
    output logic [ACC_W-1:0] m_exon_end,
    output logic             m_transcript_done
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    decode_t    dec;
    result_t    result;
    logic       emit;
    logic       advance;

    tlp_decode u_decode (
        .byte_in (in_byte_reg),
        .dec     (dec)
    );

    tlp_fields u_fields (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .dec     (dec),
        .emit    (emit),
        .result  (result)
    );

    // Advance the held byte unless it must emit into a full result slot
    assign advance = in_valid_reg && (!emit || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Hold the input request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_byte_in;
        end
    end

    // Load or drop the result request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_kind            = out_reg.kind;
    assign m_value           = out_reg.value;
    assign m_strand_minus    = out_reg.strand_minus;
    assign m_exon_start      = out_reg.exon_start;
    assign m_exon_end        = out_reg.exon_end;
    assign m_transcript_done = out_reg.transcript_done;

endmodule

/* src/tlp_decode.sv */
// Byte classifier: maps one raw text byte to its class and digit value.
// Depends on tlp_pkg.
module tlp_decode
    import tlp_pkg::*;
(
    input  logic [7:0] byte_in,
    output decode_t    dec
);

    logic [7:0] digit_off;

    assign digit_off = byte_in - CHAR_ZERO;

    // Classify the byte
    always_comb begin
        dec.digit = digit_off[3:0];
        dec.minus = (byte_in == CHAR_MINUS);
        if (byte_in >= CHAR_ZERO && byte_in <= CHAR_NINE) begin
            dec.cls = CLS_DIGIT;
        end else if (byte_in == CHAR_NEWLINE) begin
            dec.cls = CLS_NEWLINE;
        end else if (byte_in == CHAR_TAB) begin
            dec.cls = CLS_TAB;
        end else if (byte_in == CHAR_UNDERSCORE) begin
            dec.cls = CLS_UNDERSCORE;
        end else if (byte_in == CHAR_COMMA) begin
            dec.cls = CLS_COMMA;
        end else if (byte_in == CHAR_AT) begin
            dec.cls = CLS_AT;
        end else if (byte_in == CHAR_MINUS || byte_in == CHAR_PLUS) begin
            dec.cls = CLS_STRAND;
        end else begin
            dec.cls = CLS_BAD;
        end
    end

endmodule

/* src/tlp_fields.sv */
// Field state of the parser: accumulators, field select, exon start latch,
// and the result record formed from the current byte. Depends on tlp_pkg.
module tlp_fields
    import tlp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  decode_t dec,
    output logic    emit,
    output result_t result
);

    field_t           field_reg, field_next;
    logic [ACC_W-1:0] id_reg, id_next;
    logic [ACC_W-1:0] locus_reg, locus_next;
    logic [ACC_W-1:0] ref_reg, ref_next;
    logic [ACC_W-1:0] start_reg, start_next;
    logic [ACC_W-1:0] end_reg, end_next;
    logic [ACC_W-1:0] latch_reg, latch_next;
    logic [ACC_W-1:0] acc_sel;
    logic [ACC_W-1:0] acc_new;

    // Pick the accumulator of the current field and append one digit
    always_comb begin
        unique case (field_reg)
            FIELD_ID:    acc_sel = id_reg;
            FIELD_LOCUS: acc_sel = locus_reg;
            FIELD_REF:   acc_sel = ref_reg;
            FIELD_START: acc_sel = start_reg;
            FIELD_END:   acc_sel = end_reg;
            default:     acc_sel = '0;
        endcase
        acc_new = (acc_sel << 3) + (acc_sel << 1) + {{(ACC_W-4){1'b0}}, dec.digit};
    end

    // Next state and result record
    always_comb begin
        field_next = field_reg;
        id_next    = id_reg;
        locus_next = locus_reg;
        ref_next   = ref_reg;
        start_next = start_reg;
        end_next   = end_reg;
        latch_next = latch_reg;
        result     = '0;
        result.kind = KIND_BAD;
        emit       = 1'b1;

        unique case (dec.cls)
            CLS_DIGIT: begin
                emit = 1'b0;
                unique case (field_reg)
                    FIELD_ID:    id_next    = acc_new;
                    FIELD_LOCUS: locus_next = acc_new;
                    FIELD_REF:   ref_next   = acc_new;
                    FIELD_START: start_next = acc_new;
                    FIELD_END:   end_next   = acc_new;
                    default:     ;
                endcase
            end
            CLS_NEWLINE: begin
                result.kind            = KIND_EXON;
                result.exon_start      = latch_reg;
                result.exon_end        = end_reg;
                result.transcript_done = 1'b1;
                field_next             = FIELD_ID;
                end_next               = '0;
            end
            CLS_TAB: begin
                result.kind  = KIND_ID;
                result.value = id_reg;
                field_next   = FIELD_LOCUS;
                id_next      = '0;
            end
            CLS_UNDERSCORE: begin
                emit       = 1'b0;
                latch_next = start_reg;
                start_next = '0;
                field_next = FIELD_END;
            end
            CLS_COMMA: begin
                result.kind       = KIND_EXON;
                result.exon_start = latch_reg;
                result.exon_end   = end_reg;
                field_next        = FIELD_START;
                end_next          = '0;
            end
            CLS_AT: begin
                result.kind  = KIND_LOCUS;
                result.value = locus_reg;
                field_next   = FIELD_REF;
                locus_next   = '0;
            end
            CLS_STRAND: begin
                result.kind         = KIND_REF;
                result.value        = ref_reg;
                result.strand_minus = dec.minus;
                field_next          = FIELD_START;
                ref_next            = '0;
            end
            default: begin
                result.kind = KIND_BAD;
            end
        endcase
    end

    // Commit state when the byte advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_reg <= FIELD_ID;
            id_reg    <= '0;
            locus_reg <= '0;
            ref_reg   <= '0;
            start_reg <= '0;
            end_reg   <= '0;
            latch_reg <= '0;
        end else if (step) begin
            field_reg <= field_next;
            id_reg    <= id_next;
            locus_reg <= locus_next;
            ref_reg   <= ref_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            latch_reg <= latch_next;
        end
    end

endmodule
